// ===== src/lsb_pkg.sv =====
package lsb_pkg;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned ROBT_W  = 5;
  localparam int unsigned TAG_W   = 6;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OFF_W   = 12;
  localparam int unsigned CMD_W   = 4;
  localparam logic [KIND_W-1:0] KIND_LAST_LOAD = 3'd4;

  localparam int unsigned CMD_DISPATCH = 0;
  localparam int unsigned CMD_MEM_BUSY = 1;
  localparam int unsigned CMD_COMMIT   = 2;
  localparam int unsigned CMD_FLUSH    = 3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ROBT_W-1:0] rob_tag;
    logic              base_wait;
    logic [TAG_W-1:0]  base_tag;
    logic [DATA_W-1:0] address;
    logic              data_wait;
    logic [TAG_W-1:0]  data_tag;
    logic [DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] value;
  } bcast_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic flush;
  } cell_ctl_t;
endpackage

// ===== src/lsb_if.sv =====
interface lsb_in_if;
  import lsb_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [KIND_W-1:0] inst_kind;
  logic [ROBT_W-1:0] rob_tag;
  logic signed [TAG_W-1:0] base_tag;
  logic [DATA_W-1:0] base_value;
  logic signed [OFF_W-1:0] offset;
  logic signed [TAG_W-1:0] data_tag;
  logic [DATA_W-1:0] data_value;
  logic signed [TAG_W-1:0] mem_done_tag;
  logic [DATA_W-1:0] mem_done_value;
  logic signed [TAG_W-1:0] alu_done_tag;
  logic [DATA_W-1:0] alu_done_value;
  modport source (output valid, command, inst_kind, rob_tag, base_tag, base_value, offset,
                  data_tag, data_value, mem_done_tag, mem_done_value, alu_done_tag,
                  alu_done_value, input ready);
  modport sink (input valid, command, inst_kind, rob_tag, base_tag, base_value, offset,
                data_tag, data_value, mem_done_tag, mem_done_value, alu_done_tag,
                alu_done_value, output ready);
endinterface

interface lsb_out_if;
  import lsb_pkg::*;
  logic              valid;
  logic              ready;
  logic              issue_valid;
  logic [DATA_W-1:0] load_address;
  logic [KIND_W-1:0] load_kind;
  logic [ROBT_W-1:0] load_tag;
  logic              queue_full;
  logic [3:0]        queue_count;
  modport source (output valid, issue_valid, load_address, load_kind, load_tag, queue_full,
                  queue_count, input ready);
  modport sink (input valid, issue_valid, load_address, load_kind, load_tag, queue_full,
                queue_count, output ready);
endinterface

// ===== src/lsb_cell.sv =====
module lsb_cell import lsb_pkg::*; (
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  entry_t    up_i,
  input  entry_t    new_i,
  input  bcast_t    mem_i,
  input  bcast_t    alu_i,
  output entry_t    q_o
);
  entry_t ent_q, ent_d, src;

  always_comb begin
    src = ctl_i.load ? new_i : (ctl_i.shift ? up_i : ent_q);
    ent_d = src;
    if (mem_i.valid && src.base_wait && src.base_tag == mem_i.tag) begin
      ent_d.base_wait = 1'b0;
      ent_d.address   = src.address + mem_i.value;
    end else if (alu_i.valid && src.base_wait && src.base_tag == alu_i.tag) begin
      ent_d.base_wait = 1'b0;
      ent_d.address   = src.address + alu_i.value;
    end
    if (mem_i.valid && src.data_wait && src.data_tag == mem_i.tag) begin
      ent_d.data_wait = 1'b0;
      ent_d.data      = mem_i.value;
    end else if (alu_i.valid && src.data_wait && src.data_tag == alu_i.tag) begin
      ent_d.data_wait = 1'b0;
      ent_d.data      = alu_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign q_o = ent_q;
endmodule

// ===== src/load_store_buffer_wakeup.sv =====
// Load/store buffer with tag wakeup, one tick per input beat.
// Channels: in (sink) carries one tick: command, a dispatch payload and the
// memory and ALU broadcasts. out (source) carries one result beat per tick:
// issue info of the head load plus the entry count after the tick.
// The queue is a row of cells; cell 0 is the head. A dequeue shifts every
// cell toward the head, and a dispatch loads the cell at the fill count
// (after the shift). Each cell applies broadcasts to its own entry.
// The result beat follows in the cycle after its input beat is accepted. Throughput:
// one beat per cycle while out is taken; a new beat is taken in the same
// cycle the waiting result leaves, set by the single output register.
// Reset clears the count, load-in-flight flag and output valid; entry
// payloads are undefined until dispatched. When the receiver stalls, the
// result holds and in.ready stays low so no tick is lost.
module load_store_buffer_wakeup import lsb_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned ROB_TAGS    = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  lsb_in_if.sink    in_i,
  lsb_out_if.source out_o
);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count_q, count_d, count_mid;
  logic             inflight_q;
  logic             ovalid_q;
  logic             fire;
  entry_t           cells [QUEUE_DEPTH];
  entry_t           new_ent;
  bcast_t           mem_b, alu_b;
  cell_ctl_t        ctl [QUEUE_DEPTH];
  logic             issue, dispatch, deq, flush;
  logic [DATA_W-1:0] off_x;
  logic             bt_ok, dt_ok;

  assign in_i.ready = !ovalid_q || out_o.ready;
  assign fire = in_i.valid && in_i.ready;
  assign flush = in_i.command[CMD_FLUSH];

  function automatic logic tag_ok(logic [TAG_W-1:0] t);
    return !t[TAG_W-1] && (32'(t) < ROB_TAGS);
  endfunction

  assign mem_b = '{valid: tag_ok(in_i.mem_done_tag), tag: in_i.mem_done_tag,
                   value: in_i.mem_done_value};
  assign alu_b = '{valid: tag_ok(in_i.alu_done_tag), tag: in_i.alu_done_tag,
                   value: in_i.alu_done_value};

  // Issue looks at the head as it stood at the start of the tick.
  assign issue = !flush && (count_q != '0) && (cells[0].kind <= KIND_LAST_LOAD)
               && !in_i.command[CMD_MEM_BUSY] && !inflight_q && !cells[0].base_wait;
  assign dispatch = !flush && in_i.command[CMD_DISPATCH]
                  && (count_q != CNT_W'(QUEUE_DEPTH));
  assign count_mid = count_q + CNT_W'(dispatch);
  assign deq = !flush && (issue || in_i.command[CMD_COMMIT]) && (count_mid != '0);
  assign count_d = flush ? '0 : count_mid - CNT_W'(deq);

  always_comb begin
    off_x = DATA_W'(signed'(in_i.offset));
    bt_ok = tag_ok(in_i.base_tag);
    dt_ok = tag_ok(in_i.data_tag);
    new_ent.kind      = in_i.inst_kind;
    new_ent.rob_tag   = in_i.rob_tag;
    new_ent.base_wait = bt_ok;
    new_ent.base_tag  = in_i.base_tag;
    new_ent.address   = bt_ok ? off_x : in_i.base_value + off_x;
    if (in_i.inst_kind <= KIND_LAST_LOAD) begin
      new_ent.data_wait = 1'b0;
      new_ent.data_tag  = in_i.data_tag;
      new_ent.data      = '0;
    end else begin
      new_ent.data_wait = dt_ok;
      new_ent.data_tag  = in_i.data_tag;
      new_ent.data      = dt_ok ? '0 : in_i.data_value;
    end
  end

  // Dispatched slot: the tail after this tick's dequeue.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t up;
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign up = cells[g];
    end else begin : g_mid
      assign up = cells[g+1];
    end
    assign ctl[g].flush = flush;
    assign ctl[g].shift = fire && deq;
    assign ctl[g].load  = fire && dispatch && (CNT_W'(g) == count_q - CNT_W'(deq));
    lsb_cell u_cell (
      .clk_i (clk_i),
      .ctl_i (fire ? ctl[g] : '0),
      .up_i  (up),
      .new_i (new_ent),
      .mem_i (fire ? mem_b : '0),
      .alu_i (fire ? alu_b : '0),
      .q_o   (cells[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      inflight_q <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      if (fire) begin
        count_q    <= count_d;
        inflight_q <= issue;
      end
      if (fire) ovalid_q <= 1'b1;
      else if (out_o.ready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_o.issue_valid  <= issue;
      out_o.load_address <= issue ? cells[0].address : '0;
      out_o.load_kind    <= issue ? cells[0].kind : '0;
      out_o.load_tag     <= issue ? cells[0].rob_tag : '0;
      out_o.queue_full   <= (count_d == CNT_W'(QUEUE_DEPTH));
      out_o.queue_count  <= 4'(count_d);
    end
  end

  assign out_o.valid = ovalid_q;
endmodule
